// ===== src/pts_pkg.sv =====
`timescale 1ns / 1ps
package pts_pkg;

  localparam int KIND_W  = 2;
  localparam int PID_W   = 10;
  localparam int POL_W   = 2;
  localparam int STAMP_W = 32;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PICK  = 2'd2;

  localparam logic [POL_W-1:0] POL_ARB  = 2'd0;
  localparam logic [POL_W-1:0] POL_FIFO = 2'd1;
  localparam logic [POL_W-1:0] POL_LIFO = 2'd2;
  localparam logic [POL_W-1:0] POL_RR   = 2'd3;

  // register select is paddr[2]
  localparam logic REG_POLICY = 1'b0;

  typedef enum logic [1:0] {
    CMP_EQ,
    CMP_LT,
    CMP_GT
  } cmp_op_e;

endpackage

// ===== src/pts_if.sv =====
`timescale 1ns / 1ps
interface pts_evt_if import pts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [PID_W-1:0]  pid;

  modport source (output valid, kind, pid, input ready);
  modport sink   (input valid, kind, pid, output ready);
endinterface

interface pts_res_if import pts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             ok;
  logic [PID_W-1:0] chosen_pid;

  modport source (output valid, ok, chosen_pid, input ready);
  modport sink   (input valid, ok, chosen_pid, output ready);
endinterface

// ===== src/process_table_scheduler.sv =====
`timescale 1ns / 1ps
// Process table scheduler with a SLOTS-entry table and a round-robin ring.
// evt_i: valid/ready event channel (kind: start, end, pick; pid).
// res_o: valid/ready result channel, one transaction per event (ok, chosen_pid).
// APB port: register 0 (byte address 0) is the selection policy, reset to
// round robin; write it only while no event is in flight.
// Events are handled one at a time by a sequencer that walks the table and
// ring one entry per cycle through a shared comparator and memories with
// one write port and one registered read port each:
//   start: free-slot search of the table
//   end:   table walk, plus ring search and ring compaction
//   pick:  one ring read for round robin, a table scan for the other policies
// evt_i.ready is high only while the sequencer is idle. A finished result
// sits in an output register, so a new event is taken while it waits; if
// the receiver stalls, the next result holds inside until the register frees.
// Reset empties the table and ring and clears the arrival counter; no
// clearing pass is needed.
module process_table_scheduler import pts_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pts_evt_if.sink           evt_i,
  pts_res_if.source         res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [POL_W-1:0] policy;

  pts_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .policy_o (policy)
  );

  pts_core #(
    .SLOTS (SLOTS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .policy_i (policy),
    .evt_i    (evt_i),
    .res_o    (res_o)
  );

endmodule

// ===== src/pts_regs.sv =====
`timescale 1ns / 1ps
module pts_regs import pts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [POL_W-1:0]  policy_o
);

  logic [POL_W-1:0] policy_q, policy_d;

  assign pready = 1'b1;

  always_comb begin
    policy_d = policy_q;
    if (psel && penable && pwrite && (paddr[2] == REG_POLICY)) begin
      policy_d = pwdata[POL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_POLICY) begin
      prdata = {{(DATA_W-POL_W){1'b0}}, policy_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_RR;
    end else begin
      policy_q <= policy_d;
    end
  end

  assign policy_o = policy_q;

endmodule

// ===== src/pts_cmp.sv =====
`timescale 1ns / 1ps
module pts_cmp import pts_pkg::*; (
  input  cmp_op_e            op_i,
  input  logic [STAMP_W-1:0] a_i,
  input  logic [STAMP_W-1:0] b_i,
  output logic               hit_o
);

  always_comb begin
    case (op_i)
      CMP_EQ:  hit_o = (a_i == b_i);
      CMP_LT:  hit_o = (a_i < b_i);
      CMP_GT:  hit_o = (a_i > b_i);
      default: hit_o = 1'b0;
    endcase
  end

endmodule

// ===== src/pts_core.sv =====
`timescale 1ns / 1ps
module pts_core import pts_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [POL_W-1:0] policy_i,
  pts_evt_if.sink          evt_i,
  pts_res_if.source        res_o
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] SlotsC = CW'(SLOTS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FREE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_RFIND  = 3'd3;
  localparam logic [2:0] ST_RSHIFT = 3'd4;
  localparam logic [2:0] ST_RRD    = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [KIND_W-1:0]  kind_q, kind_d;
  logic [PID_W-1:0]   pid_q, pid_d;
  logic [CW-1:0]      scan_q, scan_d;
  logic               p_vld_q, p_vld_d;
  logic [IW-1:0]      p_idx_q, p_idx_d;
  logic [SLOTS-1:0]   valid_q, valid_d;
  logic [STAMP_W-1:0] cnt_q, cnt_d;
  logic [CW-1:0]      ring_cnt_q, ring_cnt_d;
  logic [IW-1:0]      head_q, head_d;
  logic [IW-1:0]      hit_idx_q, hit_idx_d;
  logic               best_have_q, best_have_d;
  logic [STAMP_W-1:0] best_stamp_q, best_stamp_d;
  logic [PID_W-1:0]   best_pid_q, best_pid_d;
  logic               res_ok_q, res_ok_d;
  logic [PID_W-1:0]   res_pid_q, res_pid_d;
  logic               out_vld_q, out_vld_d;
  logic               out_ok_q, out_ok_d;
  logic [PID_W-1:0]   out_pid_q, out_pid_d;

  logic [PID_W-1:0]   pid_mem   [SLOTS];
  logic [STAMP_W-1:0] stamp_mem [SLOTS];
  logic [PID_W-1:0]   ring_mem  [SLOTS];
  logic [PID_W-1:0]   pid_rd_q;
  logic [STAMP_W-1:0] stamp_rd_q;
  logic [PID_W-1:0]   ring_rd_q;

  logic               slot_we;
  logic [IW-1:0]      slot_wa;
  logic               ring_we;
  logic [IW-1:0]      ring_wa;
  logic [PID_W-1:0]   ring_wd;
  logic [IW-1:0]      rd_addr;

  cmp_op_e            cmp_op;
  logic [STAMP_W-1:0] cmp_a, cmp_b;
  logic               cmp_hit;

  logic [CW-1:0]      scan_lim;
  logic               issue;
  logic [IW-1:0]      head_adj;
  logic [CW-1:0]      cnt_dec;
  logic [CW-1:0]      rr_next;

  assign rd_addr = scan_q[IW-1:0];

  always_comb begin
    cmp_op = CMP_EQ;
    cmp_a  = {{(STAMP_W-PID_W){1'b0}}, ring_rd_q};
    cmp_b  = {{(STAMP_W-PID_W){1'b0}}, pid_q};
    if (state_q == ST_SCAN) begin
      if (kind_q == KIND_END) begin
        cmp_a = {{(STAMP_W-PID_W){1'b0}}, pid_rd_q};
      end else begin
        cmp_op = (policy_i == POL_FIFO) ? CMP_LT : CMP_GT;
        cmp_a  = stamp_rd_q;
        cmp_b  = best_stamp_q;
      end
    end
  end

  pts_cmp u_cmp (
    .op_i  (cmp_op),
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .hit_o (cmp_hit)
  );

  assign scan_lim = (state_q == ST_SCAN) ? SlotsC : ring_cnt_q;
  assign issue    = (scan_q < scan_lim);
  assign head_adj = (hit_idx_q < head_q) ? head_q - 1'b1 : head_q;
  assign cnt_dec  = ring_cnt_q - 1'b1;
  assign rr_next  = scan_q + 1'b1;

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    pid_d        = pid_q;
    scan_d       = scan_q;
    p_vld_d      = p_vld_q;
    p_idx_d      = p_idx_q;
    valid_d      = valid_q;
    cnt_d        = cnt_q;
    ring_cnt_d   = ring_cnt_q;
    head_d       = head_q;
    hit_idx_d    = hit_idx_q;
    best_have_d  = best_have_q;
    best_stamp_d = best_stamp_q;
    best_pid_d   = best_pid_q;
    res_ok_d     = res_ok_q;
    res_pid_d    = res_pid_q;
    out_vld_d    = out_vld_q;
    out_ok_d     = out_ok_q;
    out_pid_d    = out_pid_q;
    slot_we      = 1'b0;
    slot_wa      = scan_q[IW-1:0];
    ring_we      = 1'b0;
    ring_wa      = ring_cnt_q[IW-1:0];
    ring_wd      = pid_q;

    if (out_vld_q && res_o.ready) begin
      out_vld_d = 1'b0;
    end

    if ((state_q == ST_SCAN) || (state_q == ST_RFIND) || (state_q == ST_RSHIFT)) begin
      if (issue) begin
        scan_d  = scan_q + 1'b1;
        p_vld_d = 1'b1;
        p_idx_d = scan_q[IW-1:0];
      end else begin
        p_vld_d = 1'b0;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (evt_i.valid) begin
          kind_d      = evt_i.kind;
          pid_d       = evt_i.pid;
          scan_d      = '0;
          p_vld_d     = 1'b0;
          best_have_d = 1'b0;
          res_ok_d    = 1'b0;
          res_pid_d   = '0;
          case (evt_i.kind)
            KIND_START: state_d = ST_FREE;
            KIND_END:   state_d = ST_SCAN;
            KIND_PICK: begin
              if (policy_i == POL_RR) begin
                if (ring_cnt_q == '0) begin
                  state_d = ST_DONE;
                end else begin
                  scan_d  = (CW'(head_q) >= ring_cnt_q) ? '0 : CW'(head_q);
                  state_d = ST_RRD;
                end
              end else begin
                state_d = ST_SCAN;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end

      ST_FREE: begin
        if (!valid_q[scan_q[IW-1:0]]) begin
          if (cnt_q != '1) begin
            cnt_d = cnt_q + 1'b1;
          end
          slot_we                 = 1'b1;
          valid_d[scan_q[IW-1:0]] = 1'b1;
          if (ring_cnt_q < SlotsC) begin
            ring_we    = 1'b1;
            ring_cnt_d = ring_cnt_q + 1'b1;
          end
          res_ok_d = 1'b1;
          state_d  = ST_DONE;
        end else if (scan_q == SlotsC - 1'b1) begin
          state_d = ST_DONE;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end

      ST_SCAN: begin
        if (p_vld_q && valid_q[p_idx_q]) begin
          if (kind_q == KIND_END) begin
            if (cmp_hit) begin
              valid_d[p_idx_q] = 1'b0;
              scan_d           = '0;
              p_vld_d          = 1'b0;
              state_d          = ST_RFIND;
            end
          end else if (policy_i == POL_ARB) begin
            res_ok_d  = 1'b1;
            res_pid_d = pid_rd_q;
            state_d   = ST_DONE;
          end else if (!best_have_q || cmp_hit) begin
            best_have_d  = 1'b1;
            best_stamp_d = stamp_rd_q;
            best_pid_d   = pid_rd_q;
          end
        end else if (!p_vld_q && !issue) begin
          res_ok_d  = best_have_q;
          res_pid_d = best_have_q ? best_pid_q : '0;
          state_d   = ST_DONE;
        end
      end

      ST_RFIND: begin
        if (p_vld_q && cmp_hit) begin
          hit_idx_d = p_idx_q;
          scan_d    = CW'(p_idx_q) + 1'b1;
          p_vld_d   = 1'b0;
          state_d   = ST_RSHIFT;
        end else if (!p_vld_q && !issue) begin
          res_ok_d = 1'b1;
          state_d  = ST_DONE;
        end
      end

      ST_RSHIFT: begin
        if (p_vld_q) begin
          ring_we = 1'b1;
          ring_wa = p_idx_q - 1'b1;
          ring_wd = ring_rd_q;
        end else if (!issue) begin
          ring_cnt_d = cnt_dec;
          head_d     = (CW'(head_adj) >= cnt_dec) ? '0 : head_adj;
          res_ok_d   = 1'b1;
          state_d    = ST_DONE;
        end
      end

      ST_RRD: begin
        if (!p_vld_q) begin
          p_vld_d = 1'b1;
        end else begin
          p_vld_d   = 1'b0;
          res_ok_d  = 1'b1;
          res_pid_d = ring_rd_q;
          head_d    = (rr_next >= ring_cnt_q) ? '0 : rr_next[IW-1:0];
          state_d   = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_vld_q || res_o.ready) begin
          out_vld_d = 1'b1;
          out_ok_d  = res_ok_q;
          out_pid_d = res_pid_q;
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      p_vld_q     <= 1'b0;
      valid_q     <= '0;
      cnt_q       <= '0;
      ring_cnt_q  <= '0;
      head_q      <= '0;
      best_have_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      p_vld_q     <= p_vld_d;
      valid_q     <= valid_d;
      cnt_q       <= cnt_d;
      ring_cnt_q  <= ring_cnt_d;
      head_q      <= head_d;
      best_have_q <= best_have_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    pid_q        <= pid_d;
    p_idx_q      <= p_idx_d;
    hit_idx_q    <= hit_idx_d;
    best_stamp_q <= best_stamp_d;
    best_pid_q   <= best_pid_d;
    res_ok_q     <= res_ok_d;
    res_pid_q    <= res_pid_d;
    out_ok_q     <= out_ok_d;
    out_pid_q    <= out_pid_d;
  end

  // slot table, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      pid_mem[slot_wa]   <= pid_q;
      stamp_mem[slot_wa] <= cnt_d;
    end
    pid_rd_q   <= pid_mem[rd_addr];
    stamp_rd_q <= stamp_mem[rd_addr];
  end

  // round-robin ring
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_wa] <= ring_wd;
    end
    ring_rd_q <= ring_mem[rd_addr];
  end

  assign evt_i.ready      = (state_q == ST_IDLE);
  assign res_o.valid      = out_vld_q;
  assign res_o.ok         = out_ok_q;
  assign res_o.chosen_pid = out_pid_q;

endmodule

// ===== bench/pts_sched_checker.sv =====
`timescale 1ns / 1ps
module pts_sched_checker import pts_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pts_evt_if                evt_i,
  pts_res_if                res_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  output int                pend_o,
  output int                fails_o
);

  typedef struct packed {
    logic             ok;
    logic [PID_W-1:0] pid;
  } sched_res_t;

  logic               slot_valid [SLOTS];
  logic [PID_W-1:0]   slot_pid   [SLOTS];
  logic [STAMP_W-1:0] slot_stamp [SLOTS];
  logic [STAMP_W-1:0] arrival_cnt;
  logic [PID_W-1:0]   ring_pid   [SLOTS];
  int                 ring_head;
  int                 ring_count;
  logic [POL_W-1:0]   policy;
  sched_res_t         awaited_res_q [$];
  int                 fails;

  task automatic admit_process(input logic [PID_W-1:0] pid, output logic ok);
    int idx;
    idx = -1;
    for (int i = 0; i < SLOTS; i++)
      if (idx < 0 && !slot_valid[i]) idx = i;
    ok = (idx >= 0);
    if (ok) begin
      if (arrival_cnt != '1) arrival_cnt = arrival_cnt + 1'b1;
      slot_valid[idx] = 1'b1;
      slot_pid[idx]   = pid;
      slot_stamp[idx] = arrival_cnt;
      if (ring_count < SLOTS) begin
        ring_pid[ring_count] = pid;
        ring_count++;
      end
    end
  endtask

  task automatic retire_process(input logic [PID_W-1:0] pid, output logic ok);
    int idx;
    int n;
    idx = -1;
    n   = -1;
    for (int i = 0; i < SLOTS; i++)
      if (idx < 0 && slot_valid[i] && slot_pid[i] == pid) idx = i;
    ok = (idx >= 0);
    if (ok) begin
      slot_valid[idx] = 1'b0;
      for (int i = 0; i < ring_count; i++)
        if (n < 0 && ring_pid[i] == pid) n = i;
      if (n >= 0) begin
        // close the gap, keep the head on the same next entry
        for (int v = n; v + 1 < ring_count; v++) ring_pid[v] = ring_pid[v + 1];
        ring_count--;
        if (n < ring_head) ring_head--;
        if (ring_head >= ring_count) ring_head = 0;
      end
    end
  endtask

  task automatic pick_process(output logic ok, output logic [PID_W-1:0] chosen);
    int best;
    ok     = 1'b0;
    chosen = '0;
    best   = -1;
    if (policy == POL_RR) begin
      if (ring_count > 0) begin
        if (ring_head >= ring_count) ring_head = 0;
        chosen = ring_pid[ring_head];
        ring_head++;
        if (ring_head >= ring_count) ring_head = 0;
        ok = 1'b1;
      end
    end else begin
      // strict compares: ties go to the lowest slot
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_valid[i]) begin
          if (best < 0) best = i;
          else if (policy == POL_FIFO && slot_stamp[i] < slot_stamp[best]) best = i;
          else if (policy == POL_LIFO && slot_stamp[i] > slot_stamp[best]) best = i;
        end
      end
      if (best >= 0) begin
        ok     = 1'b1;
        chosen = slot_pid[best];
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sched_res_t want;
    sched_res_t got;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
      arrival_cnt = '0;
      ring_head   = 0;
      ring_count  = 0;
      policy      = POL_RR;
      fails       = 0;
      awaited_res_q.delete();
      pend_o  <= 0;
      fails_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_POLICY)
        policy = pwdata[POL_W-1:0];

      if (res_i.valid && res_i.ready) begin
        got.ok  = res_i.ok;
        got.pid = res_i.chosen_pid;
        if (awaited_res_q.size() == 0) begin
          $error("result transaction with none expected: ok %0d chosen_pid %0d",
                 got.ok, got.pid);
          fails++;
        end else begin
          want = awaited_res_q.pop_front();
          if (got.ok !== want.ok) begin
            $error("ok mismatch: expected %0d, actual %0d", want.ok, got.ok);
            fails++;
          end
          if (got.pid !== want.pid) begin
            $error("chosen_pid mismatch: expected %0d, actual %0d", want.pid, got.pid);
            fails++;
          end
        end
      end

      if (evt_i.valid && evt_i.ready) begin
        want = '0;
        case (evt_i.kind)
          KIND_START: admit_process(evt_i.pid, want.ok);
          KIND_END:   retire_process(evt_i.pid, want.ok);
          KIND_PICK:  pick_process(want.ok, want.pid);
          default:    want = '0;
        endcase
        awaited_res_q.push_back(want);
      end

      pend_o  <= awaited_res_q.size();
      fails_o <= fails;
    end
  end

endmodule

// ===== bench/process_table_scheduler_tb.sv =====
`timescale 1ns / 1ps
module process_table_scheduler_tb;
  import pts_pkg::*;

  localparam int                SLOTS       = 16;
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;
  localparam logic [ADDR_W-1:0] POLICY_ADDR = {REG_POLICY, 2'b00};
  localparam int                HOLD_CYCLES = 400;
  localparam int                PHASE_ITEMS = 240;
  localparam int                CYCLE_LIMIT = 2_000_000;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                pend;
  int                fails;

  pts_evt_if evt_if ();
  pts_res_if res_if ();

  process_table_scheduler #(.SLOTS(SLOTS)) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .evt_i   (evt_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pts_sched_checker #(.SLOTS(SLOTS)) u_checker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .evt_i   (evt_if),
    .res_i   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .pready  (pready),
    .pend_o  (pend),
    .fails_o (fails)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  int cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL process_table_scheduler");
      $finish;
    end
  end

  bit hold_go   = 1'b0;
  bit hold_done = 1'b0;

  // result side: stall modes picked at random, plus one long hold-off
  initial begin
    int mode;
    int mode_left;
    mode      = 0;
    mode_left = 0;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_done) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          0:       res_if.ready <= 1'b1;
          1:       res_if.ready <= ($urandom_range(0, 1) == 1);
          2:       res_if.ready <= ($urandom_range(0, 3) == 0);
          default: res_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  int burst_left = 0;
  logic [PID_W-1:0] live_q [$];

  task automatic send_evt(input logic [KIND_W-1:0] kind, input logic [PID_W-1:0] pid);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    evt_if.valid <= 1'b1;
    evt_if.kind  <= kind;
    evt_if.pid   <= pid;
    @(posedge clk_i);
    while (!evt_if.ready) @(posedge clk_i);
    burst_left--;
    if (burst_left == 0) evt_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    if (burst_left != 0) begin
      evt_if.valid <= 1'b0;
      burst_left = 0;
    end
    @(posedge clk_i);
    while (pend != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_policy(input logic [POL_W-1:0] pol);
    logic [DATA_W-1:0] wdata;
    wait_idle();
    wdata            = $urandom();
    wdata[POL_W-1:0] = pol;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= POLICY_ADDR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [PID_W-1:0] rand_pid();
    if ($urandom_range(0, 4) == 0) return PID_W'($urandom_range(0, 1023));
    return PID_W'($urandom_range(0, 23));
  endfunction

  task automatic run_phase(input int n_items);
    int sent;
    int sel;
    int idx;
    int r;
    logic [PID_W-1:0] p;
    sent = 0;
    while (sent < n_items) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        // fill past capacity
        repeat ($urandom_range(17, 20)) begin
          p = rand_pid();
          send_evt(KIND_START, p);
          live_q.push_back(p);
          sent++;
        end
      end else if (sel == 1) begin
        while (live_q.size() > 0) begin
          idx = $urandom_range(0, live_q.size() - 1);
          send_evt(KIND_END, PID_W'(live_q[idx]));
          live_q.delete(idx);
          sent++;
        end
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          p = rand_pid();
          send_evt(KIND_START, p);
          live_q.push_back(p);
        end else if (r < 65) begin
          if (live_q.size() > 0 && $urandom_range(0, 4) != 0) begin
            idx = $urandom_range(0, live_q.size() - 1);
            send_evt(KIND_END, PID_W'(live_q[idx]));
            live_q.delete(idx);
          end else begin
            send_evt(KIND_END, rand_pid());
          end
        end else if (r < 96) begin
          send_evt(KIND_PICK, PID_W'($urandom_range(0, 1023)));
        end else begin
          send_evt(KIND_NONE, PID_W'($urandom_range(0, 1023)));
        end
        sent++;
      end
    end
  endtask

  initial begin
    logic [POL_W-1:0] pol_seq [8];
    pol_seq = '{POL_FIFO, POL_LIFO, POL_ARB, POL_RR, POL_ARB, POL_FIFO, POL_LIFO, POL_RR};
    rst_ni       <= 1'b0;
    evt_if.valid <= 1'b0;
    evt_if.kind  <= KIND_START;
    evt_if.pid   <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: round robin out of reset, then picks under each other policy
    send_evt(KIND_PICK, 10'd0);
    send_evt(KIND_END, 10'd5);
    send_evt(KIND_NONE, 10'd1023);
    send_evt(KIND_START, 10'd0);
    send_evt(KIND_START, 10'd1023);
    send_evt(KIND_START, 10'd1023);
    send_evt(KIND_START, 10'd341);
    send_evt(KIND_START, 10'd682);
    send_evt(KIND_PICK, 10'd1023);
    send_evt(KIND_PICK, 10'd0);
    send_evt(KIND_PICK, 10'd0);
    send_evt(KIND_END, 10'd1023);
    send_evt(KIND_PICK, 10'd0);
    set_policy(POL_ARB);
    send_evt(KIND_PICK, 10'd0);
    set_policy(POL_FIFO);
    send_evt(KIND_PICK, 10'd0);
    set_policy(POL_LIFO);
    send_evt(KIND_PICK, 10'd0);
    send_evt(KIND_END, 10'd682);
    send_evt(KIND_PICK, 10'd0);
    set_policy(POL_RR);
    send_evt(KIND_PICK, 10'd0);
    send_evt(KIND_END, 10'd0);
    send_evt(KIND_PICK, 10'd0);
    live_q.push_back(10'd1023);
    live_q.push_back(10'd341);

    for (int ph = 0; ph < 8; ph++) begin
      set_policy(ph < 4 ? pol_seq[ph] : POL_W'($urandom_range(0, 3)));
      if (ph == 0) hold_go = 1'b1;
      run_phase(PHASE_ITEMS);
    end

    wait_idle();
    repeat (60) @(posedge clk_i);
    if (fails == 0) begin
      $display("PASS process_table_scheduler");
    end else begin
      $display("FAIL process_table_scheduler");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/pts_pkg.sv
src/pts_if.sv
src/pts_regs.sv
src/pts_cmp.sv
src/pts_core.sv
src/process_table_scheduler.sv
bench/pts_sched_checker.sv
bench/process_table_scheduler_tb.sv
